[rtl/tbpg_pkg.sv]
// Shared types and constants for the track background pixel generator.
`default_nettype none
package tbpg_pkg;

  localparam int unsigned STORE_AW = 11;
  localparam int unsigned CNT_W    = 11;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam logic [1:0] REG_SCROLL = 2'd0;
  localparam logic [1:0] REG_UPPER  = 2'd1;
  localparam logic [1:0] REG_LOWER  = 2'd2;
  localparam logic [1:0] REG_ICE    = 2'd3;

  localparam logic [CNT_W-1:0] HCOUNT_OFFSET = 11'h050;
  localparam logic [CNT_W-1:0] HCOUNT_WRAP   = 11'h200;
  localparam logic [CNT_W-1:0] HCOUNT_STEP   = 11'h1c8;
  localparam logic [8:0]       STREET_BASE   = 9'd128;
  localparam logic [3:0]       PEN_WHITE     = 4'd15;
  localparam logic [3:0]       PEN_BLACK     = 4'd0;

  typedef struct packed {
    logic street;
    logic white;
    logic nib_hi;
  } pix_info_t;

endpackage : tbpg_pkg
`default_nettype wire

[rtl/tbpg_front.sv]
// Horizontal count, ice colour, band decode and store address for one pixel.
`default_nettype none
module tbpg_front (
  input  wire logic [8:0]                    pixel_x,
  input  wire logic [7:0]                    pixel_y,
  input  wire logic [8:0]                    scroll_horizontal,
  input  wire logic [6:0]                    upper_boundary,
  input  wire logic [6:0]                    lower_boundary,
  input  wire logic [2:0]                    ice_mode,
  output logic [tbpg_pkg::STORE_AW-1:0]      rd_addr,
  output tbpg_pkg::pix_info_t                info
);
  import tbpg_pkg::*;

  logic [CNT_W-1:0] cx;
  logic [CNT_W-1:0] cx_wrap;
  logic             past_wrap;
  logic             upper_band;
  logic [6:0]       bnd;
  logic [4:0]       cy;

  always_comb begin
    cx        = {2'b00, pixel_x} + {2'b00, scroll_horizontal} + HCOUNT_OFFSET;
    past_wrap = (cx >= HCOUNT_WRAP);
    cx_wrap   = past_wrap ? (cx - HCOUNT_STEP) : cx;

    // Whole street white wins over the half-white split
    if (ice_mode[1]) begin
      info.white = 1'b1;
    end else if (ice_mode[2]) begin
      info.white = ice_mode[0] ? !past_wrap : past_wrap;
    end else begin
      info.white = 1'b0;
    end

    upper_band  = ({1'b0, pixel_y} < {2'b00, upper_boundary});
    info.street = !upper_band &&
                  ({1'b0, pixel_y} < (STREET_BASE + {2'b00, lower_boundary}));
    bnd         = upper_band ? upper_boundary : lower_boundary;
    cy          = pixel_y[4:0] - bnd[4:0];
    info.nib_hi = cx_wrap[1];
    rd_addr     = {cx_wrap[7:5], cy, cx_wrap[4:2]};
  end

endmodule : tbpg_front
`default_nettype wire

[rtl/tbpg_store.sv]
// Track graphics store: 2048 bytes, one write port, one registered read port.
`default_nettype none
module tbpg_store (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [tbpg_pkg::STORE_AW-1:0] waddr,
  input  wire logic [7:0]                   wdata,
  input  wire logic                         re,
  input  wire logic [tbpg_pkg::STORE_AW-1:0] raddr,
  output logic [7:0]                        rdata
);
  import tbpg_pkg::*;

  logic [7:0] mem [2**STORE_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tbpg_store
`default_nettype wire

[rtl/track_background_pixel_generator.sv]
// Top level of the track background pixel generator.
//
//  port group  | dir | word contents
//  ------------+-----+------------------------------------------------------
//  s_*         | in  | load or pixel word; tuser = operation
//  m_*         | out | pixel pen, tdata[3:0] = color
//  APB p*      | in  | scroll, upper/lower boundary, ice mode at 0x0..0xC
//
// One word is taken per cycle while m_tready does not stall the pipe; a pixel passes the
// store read register, then the output register. Loads write the store on the
// cycle they are taken and give no output word.
// Reset clears the APB registers and the valid flags; the store, pixel info and colour registers are not cleared.
// A stall on m_tready holds the whole pipe, s_tready included.
`default_nettype none
module track_background_pixel_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // pixel_x[8:0], pixel_y[16:9], load_address[27:17],
                                     // load_byte[35:28], zero [39:36]
  input  wire logic        s_tuser,  // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // color[3:0], zero [7:4]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tbpg_pkg::*;

  logic [8:0]          scroll_horizontal;
  logic [6:0]          upper_boundary;
  logic [6:0]          lower_boundary;
  logic [2:0]          ice_mode;

  logic                en;
  logic                s_acc;
  logic                is_load;
  logic [STORE_AW-1:0] rd_addr;
  pix_info_t           info;
  pix_info_t           p1_info;
  logic                p1_valid;
  logic [7:0]          rdata;
  logic [3:0]          pen;
  logic [3:0]          color;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_horizontal <= '0;
      upper_boundary    <= '0;
      lower_boundary    <= '0;
      ice_mode          <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_SCROLL: scroll_horizontal <= pwdata[8:0];
        REG_UPPER:  upper_boundary    <= pwdata[6:0];
        REG_LOWER:  lower_boundary    <= pwdata[6:0];
        REG_ICE:    ice_mode          <= pwdata[2:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCROLL: prdata = {23'd0, scroll_horizontal};
      REG_UPPER:  prdata = {25'd0, upper_boundary};
      REG_LOWER:  prdata = {25'd0, lower_boundary};
      REG_ICE:    prdata = {29'd0, ice_mode};
      default:    prdata = '0;
    endcase
  end

  // Advance the pipe whenever the output register is free or draining
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign s_acc    = s_tvalid && s_tready;
  assign is_load  = (s_tuser == OP_LOAD);

  tbpg_front u_front (
    .pixel_x           (s_tdata[8:0]),
    .pixel_y           (s_tdata[16:9]),
    .scroll_horizontal (scroll_horizontal),
    .upper_boundary    (upper_boundary),
    .lower_boundary    (lower_boundary),
    .ice_mode          (ice_mode),
    .rd_addr           (rd_addr),
    .info              (info)
  );

  tbpg_store u_store (
    .clk   (clk),
    .we    (s_acc && is_load),
    .waddr (s_tdata[27:17]),
    .wdata (s_tdata[35:28]),
    .re    (en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= s_acc && !is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_info <= info;
    end
  end

  always_comb begin
    if (p1_info.street) begin
      pen = p1_info.white ? PEN_WHITE : PEN_BLACK;
    end else begin
      pen = p1_info.nib_hi ? rdata[7:4] : rdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color <= pen;
    end
  end

  assign m_tdata = {4'd0, color};

  a_load_no_word: assert property (@(posedge clk) disable iff (rst)
    (s_acc && is_load) |=> !p1_valid)
    else $error("load word entered the pixel pipe");

  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    (s_acc && !is_load) |=> p1_valid)
    else $error("pixel word lost at the store read stage");

  a_pixel_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (p1_valid && en) |=> m_tvalid)
    else $error("pixel word lost at the output register");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(p1_valid) && $stable(p1_info) && $stable(color)))
    else $error("pipe moved during an output stall");

endmodule : track_background_pixel_generator
`default_nettype wire
